// ----- src/rttd_pkg.sv -----
// Shared widths, constants and divider request/response types for the tap detector.
package rttd_pkg;

  localparam int RD_W       = 10;
  localparam int PRES_W     = 15;
  localparam int COL_W      = 9;
  localparam int ROW_W      = 8;
  localparam int SPAN_W     = 12;
  localparam int NUM_W      = RD_W + SPAN_W;
  localparam int CNT_W      = $clog2(NUM_W + 1);
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;

  localparam logic [RD_W-1:0] FULL_SCALE = 10'd1023;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_HORIZ_MIN = 3'd0,
    REG_HORIZ_MAX = 3'd1,
    REG_VERT_MIN  = 3'd2,
    REG_VERT_MAX  = 3'd3,
    REG_PRESS     = 3'd4,
    REG_RELEASE   = 3'd5,
    REG_FLIP      = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [RD_W-1:0]  den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

// ----- src/resistive_touch_tap_detector.sv -----
// Top level of the resistive touch tap detector with calibration mapping.
// A sample with no new touch goes from S_IDLE through S_EVAL to S_OUT, which loads the result
// register once the output slot is free. A sample that starts a touch runs two 22-step divisions
// on the shared iterative divider (skipped for a zero span), each set up in S_MUL and S_START.
// One request is worked on at a time; a waiting result does not block acceptance.
// Synchronous active-low reset restores calibration defaults and clears touch state.
module resistive_touch_tap_detector #(
  parameter int SCREEN_WIDTH  = 320,
  parameter int SCREEN_HEIGHT = 240
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // touch_x_reading, touch_y_reading, plate_xm_reading, plate_yp_reading, point_pressure
  input  logic [rttd_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tap, touching, screen_x, screen_y, tap_pressure
  output logic [rttd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_wr_en,
  input  logic [rttd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rttd_pkg::RD_W-1:0]       cfg_wdata
);
  import rttd_pkg::*;

  localparam logic [SPAN_W-1:0] SPAN_COL = SPAN_W'(SCREEN_WIDTH);
  localparam logic [SPAN_W-1:0] SPAN_ROW = SPAN_W'(SCREEN_HEIGHT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]            state_r;
  logic [RD_W-1:0]       hmin_r, hmax_r, vmin_r, vmax_r, press_th_r, rel_th_r;
  logic                  flip_r;
  logic [RD_W-1:0]       tx_r, ty_r, xm_r, yp_r;
  logic [PRES_W-1:0]     pp_r;
  logic                  pressed_r;
  logic                  tap_r;
  logic                  axis_r;
  logic [NUM_W-1:0]      mag_r;
  logic [RD_W-1:0]       den_r;
  logic                  neg_r;
  logic                  dzero_r;
  logic [SPAN_W-1:0]     colv_r, rowv_r;
  logic [COL_W-1:0]      held_col_r;
  logic [ROW_W-1:0]      held_row_r;
  logic [PRES_W-1:0]     held_pres_r;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [RD_W:0]     pres_sum;
  logic [RD_W-1:0]   pres;
  logic              now_set, now_val;
  logic [RD_W-1:0]   sel_v, sel_lo, sel_hi;
  logic [SPAN_W-1:0] sel_span;
  logic [RD_W:0]     ndiff, ddiff, nabs, dabs;
  logic [SPAN_W-1:0] clamped;
  logic [SPAN_W-1:0] col_f, row_f;
  logic              slot_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  rttd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign slot_free  = !out_tvalid_r || out_tready;

  assign pres_sum = {1'b0, xm_r} + {1'b0, FULL_SCALE - yp_r};
  assign pres     = pres_sum[RD_W:1];
  assign now_set  = pressed_r || (pres > press_th_r);
  assign now_val  = now_set && !(pres < rel_th_r);

  always_comb begin
    if (!axis_r) begin
      sel_v    = ty_r;
      sel_lo   = hmin_r;
      sel_hi   = hmax_r;
      sel_span = SPAN_COL;
    end else begin
      sel_v    = tx_r;
      sel_lo   = vmax_r;
      sel_hi   = vmin_r;
      sel_span = SPAN_ROW;
    end
  end

  assign ndiff = {1'b0, sel_v} - {1'b0, sel_lo};
  assign ddiff = {1'b0, sel_hi} - {1'b0, sel_lo};
  assign nabs  = ndiff[RD_W] ? (~ndiff + 1'b1) : ndiff;
  assign dabs  = ddiff[RD_W] ? (~ddiff + 1'b1) : ddiff;

  always_comb begin
    if (neg_r) begin
      clamped = '0;
    end else if (div_rsp.quot > NUM_W'(sel_span)) begin
      clamped = sel_span;
    end else begin
      clamped = div_rsp.quot[SPAN_W-1:0];
    end
  end

  assign col_f = flip_r ? (SPAN_COL - colv_r) : colv_r;
  assign row_f = flip_r ? (SPAN_ROW - rowv_r) : rowv_r;

  assign div_req.start = (state_r == S_START) && !dzero_r;
  assign div_req.num   = mag_r;
  assign div_req.den   = den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hmin_r     <= 10'd110;
      hmax_r     <= 10'd892;
      vmin_r     <= 10'd160;
      vmax_r     <= 10'd876;
      press_th_r <= 10'd200;
      rel_th_r   <= 10'd100;
      flip_r     <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_HORIZ_MIN: hmin_r     <= cfg_wdata;
        REG_HORIZ_MAX: hmax_r     <= cfg_wdata;
        REG_VERT_MIN:  vmin_r     <= cfg_wdata;
        REG_VERT_MAX:  vmax_r     <= cfg_wdata;
        REG_PRESS:     press_th_r <= cfg_wdata;
        REG_RELEASE:   rel_th_r   <= cfg_wdata;
        REG_FLIP:      flip_r     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pressed_r    <= 1'b0;
      held_col_r   <= '0;
      held_row_r   <= '0;
      held_pres_r  <= '0;
      out_tvalid_r <= 1'b0;
      axis_r       <= 1'b0;
    end else begin
      if (state_r == S_OUT && slot_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          pressed_r <= now_val;
          axis_r    <= 1'b0;
          state_r   <= (!pressed_r && now_val) ? S_MUL : S_OUT;
        end
        S_MUL: begin
          state_r <= S_START;
        end
        S_START: begin
          if (dzero_r) begin
            axis_r  <= 1'b1;
            state_r <= axis_r ? S_FIN : S_MUL;
          end else begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            axis_r  <= 1'b1;
            state_r <= axis_r ? S_FIN : S_MUL;
          end
        end
        S_FIN: begin
          held_col_r  <= col_f[COL_W-1:0];
          held_row_r  <= row_f[ROW_W-1:0];
          held_pres_r <= pp_r;
          state_r     <= S_OUT;
        end
        S_OUT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tx_r <= in_tdata[9:0];
      ty_r <= in_tdata[19:10];
      xm_r <= in_tdata[29:20];
      yp_r <= in_tdata[39:30];
      pp_r <= in_tdata[54:40];
    end
    if (state_r == S_EVAL) begin
      tap_r <= !pressed_r && now_val;
    end
    if (state_r == S_MUL) begin
      mag_r   <= nabs[RD_W-1:0] * sel_span;
      den_r   <= dabs[RD_W-1:0];
      neg_r   <= ndiff[RD_W] ^ ddiff[RD_W];
      dzero_r <= (ddiff == '0);
    end
    if ((state_r == S_START && dzero_r) || (state_r == S_DIV && div_rsp.done)) begin
      if (!axis_r) begin
        colv_r <= (state_r == S_START) ? '0 : clamped;
      end else begin
        rowv_r <= (state_r == S_START) ? '0 : clamped;
      end
    end
    if (state_r == S_OUT && slot_free) begin
      out_tdata_r <= OUT_DATA_W'({held_pres_r, held_row_r, held_col_r, pressed_r, tap_r});
    end
  end

endmodule

// ----- src/rttd_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, unsigned magnitudes.
module rttd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rttd_pkg::div_req_t req,
  output rttd_pkg::div_rsp_t rsp
);
  import rttd_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [RD_W-1:0]  rem_r;
  logic [RD_W-1:0]  den_r;
  logic [RD_W:0]    rem_shift;
  logic [RD_W+1:0]  diff;
  logic             qbit;

  assign rem_shift = {rem_r, num_r[NUM_W-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, den_r};
  assign qbit      = ~diff[RD_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], qbit};
      rem_r <= qbit ? diff[RD_W-1:0] : rem_shift[RD_W-1:0];
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;

endmodule

// ----- src/rttd_checker.sv -----
// Port-level checker for the tap detector, bound to the top level.
module rttd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or was dropped.");

  a_tap_touching: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (!out_tdata[0] || out_tdata[1]))
    else $error("Tap reported without the touch flag set.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid directly after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("New request accepted while the previous one is in work.");

endmodule

bind resistive_touch_tap_detector rttd_checker u_rttd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

// ----- tb/sv/resistive_touch_tap_detector_test.sv -----
// Self-checking stream testbench for the resistive touch tap detector with its own tap predictor.
module resistive_touch_tap_detector_test;
  import rttd_pkg::*;

  localparam int SCREEN_W = 320;
  localparam int SCREEN_H = 240;
  localparam int NUM_REGS = 7;

  typedef logic [NUM_REGS-1:0][RD_W-1:0] cal_set_t;

  typedef struct packed {
    logic [RD_W-1:0]   x_rd;
    logic [RD_W-1:0]   y_rd;
    logic [RD_W-1:0]   xm_rd;
    logic [RD_W-1:0]   yp_rd;
    logic [PRES_W-1:0] pt_pres;
  } sample_t;

  typedef struct packed {
    logic              tap;
    logic              touching;
    logic [COL_W-1:0]  column;
    logic [ROW_W-1:0]  row;
    logic [PRES_W-1:0] pressure;
  } report_t;

  class tap_predictor;
    cal_set_t          cal;
    bit                pressed;
    logic [COL_W-1:0]  col_hold;
    logic [ROW_W-1:0]  row_hold;
    logic [PRES_W-1:0] pres_hold;
    report_t           expected_reports[$];
    int                mismatches;
    int                samples;
    int                taps;

    function new();
      cal = '0;
      cal[REG_HORIZ_MIN] = 10'd110;
      cal[REG_HORIZ_MAX] = 10'd892;
      cal[REG_VERT_MIN]  = 10'd160;
      cal[REG_VERT_MAX]  = 10'd876;
      cal[REG_PRESS]     = 10'd200;
      cal[REG_RELEASE]   = 10'd100;
      cal[REG_FLIP]      = 10'd0;
      pressed = 1'b0;
      col_hold = '0;
      row_hold = '0;
      pres_hold = '0;
      mismatches = 0;
      samples = 0;
      taps = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [RD_W-1:0] v);
      cal[idx] = (idx == REG_FLIP) ? {9'd0, v[0]} : v;
    endfunction

    function longint map_axis(longint v, longint lo, longint hi, longint span);
      longint den;
      den = hi - lo;
      if (den == 0) return 0;
      return ((v - lo) * span) / den;
    endfunction

    function void note_sample(sample_t s);
      int unsigned pres;
      bit      was;
      bit      now_on;
      longint  col;
      longint  row;
      report_t r;
      pres = (int'(s.xm_rd) + (1023 - int'(s.yp_rd))) / 2;
      was = pressed;
      now_on = was;
      if (!now_on && pres > cal[REG_PRESS]) now_on = 1'b1;
      if (now_on && pres < cal[REG_RELEASE]) now_on = 1'b0;
      pressed = now_on;
      r.tap = 1'b0;
      if (!was && now_on) begin
        col = map_axis(s.y_rd, cal[REG_HORIZ_MIN], cal[REG_HORIZ_MAX], SCREEN_W);
        row = map_axis(s.x_rd, cal[REG_VERT_MAX], cal[REG_VERT_MIN], SCREEN_H);
        if (col < 0) col = 0;
        if (col > SCREEN_W) col = SCREEN_W;
        if (row < 0) row = 0;
        if (row > SCREEN_H) row = SCREEN_H;
        if (cal[REG_FLIP][0]) begin
          col = SCREEN_W - col;
          row = SCREEN_H - row;
        end
        col_hold = col[COL_W-1:0];
        row_hold = row[ROW_W-1:0];
        pres_hold = s.pt_pres;
        r.tap = 1'b1;
        taps++;
      end
      r.touching = now_on;
      r.column = col_hold;
      r.row = row_hold;
      r.pressure = pres_hold;
      expected_reports.push_back(r);
      samples++;
    endfunction

    function void check_report(report_t got);
      report_t want;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result %p with no request outstanding", got);
        return;
      end
      want = expected_reports.pop_front();
      if (got.tap !== want.tap || got.touching !== want.touching ||
          got.column !== want.column || got.row !== want.row ||
          got.pressure !== want.pressure) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: tap %0d/%0d touching %0d/%0d x %0d/%0d y %0d/%0d pres %0d/%0d",
                   want.tap, got.tap, want.touching, got.touching, want.column, got.column,
                   want.row, got.row, want.pressure, got.pressure);
      end
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [RD_W-1:0]       cfg_wdata = '0;

  tap_predictor predictor = new();
  int burst_left = 0;
  int settings_used = 0;
  int stall_mode = 0;
  int stall_left = 0;

  resistive_touch_tap_detector #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_tready = 1'b1;
      1: out_tready = $urandom_range(0, 1);
      default: out_tready = ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      predictor.check_report('{tap: out_tdata[0], touching: out_tdata[1],
                               column: out_tdata[10:2], row: out_tdata[18:11],
                               pressure: out_tdata[33:19]});
    end
  end

  function automatic int clip10(int v);
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  function automatic sample_t make_sample(int rx, int ry, int p, int pp);
    sample_t s;
    int sum2;
    int xm;
    sum2 = 2 * clip10(p) + $urandom_range(0, 1);
    if (sum2 > 2046) sum2 = 2046;
    xm = $urandom_range((sum2 > 1023) ? sum2 - 1023 : 0, (sum2 < 1023) ? sum2 : 1023);
    s.x_rd = RD_W'(rx);
    s.y_rd = RD_W'(ry);
    s.xm_rd = RD_W'(xm);
    s.yp_rd = RD_W'(xm + 1023 - sum2);
    s.pt_pres = PRES_W'(pp);
    return s;
  endfunction

  function automatic int pick_reading(int a, int b);
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1023);
    return $urandom_range(clip10(((a < b) ? a : b) - 8), clip10(((a > b) ? a : b) + 8));
  endfunction

  function automatic int above_press();
    int t;
    t = predictor.cal[REG_PRESS];
    return (t < 1023) ? $urandom_range(t + 1, 1023) : 1023;
  endfunction

  function automatic int below_release();
    int t;
    t = predictor.cal[REG_RELEASE];
    return (t > 0) ? $urandom_range(0, t - 1) : 0;
  endfunction

  task automatic send_sample(input sample_t s);
    int gap;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, s.pt_pres, s.yp_rd, s.xm_rd, s.y_rd, s.x_rd};
    do @(posedge clk); while (!in_tready);
    predictor.note_sample(s);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid = 1'b0;
    while (predictor.pending() != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input int v);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = RD_W'(v);
    predictor.set_reg(idx, RD_W'(v));
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic write_config(input cal_set_t c);
    for (int i = 0; i < NUM_REGS; i++) write_reg(cfg_reg_t'(i), c[i]);
    settings_used++;
  endtask

  function automatic cal_set_t make_cal(int hmin, int hmax, int vmin, int vmax,
                                         int press, int rel, int flip);
    cal_set_t c;
    c[REG_HORIZ_MIN] = RD_W'(hmin);
    c[REG_HORIZ_MAX] = RD_W'(hmax);
    c[REG_VERT_MIN] = RD_W'(vmin);
    c[REG_VERT_MAX] = RD_W'(vmax);
    c[REG_PRESS] = RD_W'(press);
    c[REG_RELEASE] = RD_W'(rel);
    c[REG_FLIP] = RD_W'(flip);
    return c;
  endfunction

  task automatic run_strokes(input int n);
    int target;
    int kind;
    int rx;
    int ry;
    int pp;
    int k;
    sample_t s;
    target = predictor.samples + n;
    while (predictor.samples < target) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        rx = pick_reading(predictor.cal[REG_VERT_MIN], predictor.cal[REG_VERT_MAX]);
        ry = pick_reading(predictor.cal[REG_HORIZ_MIN], predictor.cal[REG_HORIZ_MAX]);
        pp = $urandom_range(0, 32767);
        for (k = $urandom_range(0, 2); k > 0; k--)
          send_sample(make_sample(rx, ry, below_release(), $urandom_range(0, 32767)));
        send_sample(make_sample(rx, ry, above_press(), pp));
        for (k = $urandom_range(0, 5); k > 0; k--)
          send_sample(make_sample(clip10(rx + $urandom_range(0, 20) - 10),
                                  clip10(ry + $urandom_range(0, 20) - 10),
                                  $urandom_range(predictor.cal[REG_RELEASE], 1023),
                                  $urandom_range(0, 32767)));
        for (k = $urandom_range(1, 3); k > 0; k--)
          send_sample(make_sample(rx, ry, below_release(), $urandom_range(0, 32767)));
      end else if (kind < 9) begin
        s = {RD_W'($urandom_range(0, 1023)), RD_W'($urandom_range(0, 1023)),
             RD_W'($urandom_range(0, 1023)), RD_W'($urandom_range(0, 1023)),
             PRES_W'($urandom_range(0, 32767))};
        send_sample(s);
      end else begin
        k = ($urandom_range(0, 1) == 0) ? predictor.cal[REG_PRESS] : predictor.cal[REG_RELEASE];
        send_sample(make_sample($urandom_range(0, 1023), $urandom_range(0, 1023),
                                k + $urandom_range(0, 4) - 2, $urandom_range(0, 32767)));
      end
    end
  endtask

  initial begin
    #2_000_000;
    $display("Timeout: the block stopped making progress.");
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_sample(make_sample(0, 0, 0, 0));
    send_sample(make_sample(0, 0, 1023, 32767));
    send_sample(make_sample(1023, 1023, 1023, 12345));
    send_sample(make_sample(512, 512, 99, 0));
    send_sample(make_sample(1023, 1023, 1023, 0));
    send_sample(make_sample(300, 300, 150, 1));
    send_sample(make_sample(300, 300, 100, 2));
    send_sample(make_sample(300, 300, 99, 3));
    send_sample(make_sample(300, 300, 200, 4));
    send_sample(make_sample(500, 600, 201, 777));
    send_sample(make_sample(0, 0, 0, 0));
    settle();

    // Press level below release level: the flag sets and clears in one sample.
    write_reg(REG_PRESS, 100);
    write_reg(REG_RELEASE, 200);
    send_sample(make_sample(500, 500, 150, 55));
    send_sample(make_sample(500, 500, 201, 66));
    send_sample(make_sample(500, 500, 0, 0));
    settle();

    // Zero calibration spans with the screen mirrored.
    write_config(make_cal(400, 400, 400, 400, 200, 100, 1));
    send_sample(make_sample(123, 456, 1023, 999));
    send_sample(make_sample(0, 0, 0, 0));
    settle();

    write_config(make_cal(110, 892, 160, 876, 200, 100, 0));
    run_strokes(60);
    settle();
    write_config(make_cal(0, 1023, 1023, 0, 0, 1023, 1));
    run_strokes(60);
    settle();
    write_config(make_cal(1023, 0, 0, 1023, 1023, 0, 0));
    run_strokes(20);
    settle();
    write_config(make_cal(500, 500, 300, 300, 300, 200, 1));
    run_strokes(60);
    settle();
    write_config(make_cal(900, 100, 800, 50, 600, 50, 0));
    run_strokes(60);
    settle();
    for (int i = 0; i < 3; i++) begin
      write_config(make_cal($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1)));
      run_strokes(60);
      settle();
    end
    write_config(make_cal(110, 892, 160, 876, 200, 100, 0));
    run_strokes(60);
    settle();

    $display("Sent %0d touch samples under %0d calibration settings, %0d of them taps.",
             predictor.samples, settings_used, predictor.taps);
    $display("Mismatches found: %0d.", predictor.mismatches);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/rttd_pkg.sv
src/rttd_div.sv
src/resistive_touch_tap_detector.sv
src/rttd_checker.sv
tb/sv/resistive_touch_tap_detector_test.sv
